// ===== hdl/sme_pkg.sv =====
`timescale 1ns / 1ps
package sme_pkg;

  localparam int unsigned StackDepth  = 256;
  localparam int unsigned HeapEntries = 256;
  localparam int unsigned CallDepth   = 64;
  localparam int unsigned ProgWords   = 1024;

  localparam int unsigned OpW   = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned PcW   = 10;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatW = 4;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,  OP_COPY  = 5'd1,  OP_SLIDE = 5'd2,  OP_DUP   = 5'd3,
    OP_SWAP  = 5'd4,  OP_DROP  = 5'd5,  OP_ADD   = 5'd6,  OP_SUB   = 5'd7,
    OP_MUL   = 5'd8,  OP_DIV   = 5'd9,  OP_MOD   = 5'd10, OP_STORE = 5'd11,
    OP_LOAD  = 5'd12, OP_OUTC  = 5'd13, OP_OUTN  = 5'd14, OP_INC   = 5'd15,
    OP_INN   = 5'd16, OP_CALL  = 5'd17, OP_JUMP  = 5'd18, OP_BZ    = 5'd19,
    OP_BN    = 5'd20, OP_RET   = 5'd21, OP_EXIT  = 5'd22, OP_END   = 5'd23
  } op_e;

  localparam logic [StatW-1:0] ST_OK      = 4'd0;
  localparam logic [StatW-1:0] ST_UNDER   = 4'd1;
  localparam logic [StatW-1:0] ST_RANGE   = 4'd2;
  localparam logic [StatW-1:0] ST_DIVZERO = 4'd3;
  localparam logic [StatW-1:0] ST_UNSET   = 4'd4;
  localparam logic [StatW-1:0] ST_NORET   = 4'd5;
  localparam logic [StatW-1:0] ST_SFULL   = 4'd6;
  localparam logic [StatW-1:0] ST_RFULL   = 4'd7;
  localparam logic [StatW-1:0] ST_HFULL   = 4'd8;
  localparam logic [StatW-1:0] ST_NOEXIT  = 4'd9;

  localparam logic [KindW-1:0] KIND_NONE = 2'd0;
  localparam logic [KindW-1:0] KIND_CHAR = 2'd1;
  localparam logic [KindW-1:0] KIND_NUM  = 2'd2;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/stack_machine_executor_top.sv =====
`timescale 1ns / 1ps
// One decoded instruction per input beat, one result beat per instruction, one instruction
// at a time. Operand stack, heap keys, heap values and return stack sit in memories with a
// registered read; heap valid marks are flip-flops cleared by reset. Every opcode reads the
// stack in S_RD1 and S_RD2 and then executes in S_EXEC, where stack, flow, add and sub
// opcodes and every error found at decode finish; swap writes its second word in S_WB2,
// mul writes back in S_MUL, div and mod wait in S_DIV on the 32-step restoring divider;
// store, load, in char and in number walk the heap one entry a cycle, ending early on a key
// match. The input side is ready again the cycle after the result beat is taken.
module stack_machine_executor_top #(
  parameter int unsigned STACK_DEPTH  = sme_pkg::StackDepth,
  parameter int unsigned HEAP_ENTRIES = sme_pkg::HeapEntries,
  parameter int unsigned CALL_DEPTH   = sme_pkg::CallDepth,
  parameter int unsigned PROG_WORDS   = sme_pkg::ProgWords
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sme_pkg::OpW-1:0]             opcode_i,
  input  logic signed [sme_pkg::DataW-1:0]    operand_i,
  input  logic signed [sme_pkg::DataW-1:0]    in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sme_pkg::PcW-1:0]             next_pc_o,
  output logic [sme_pkg::KindW-1:0]           out_kind_o,
  output logic signed [sme_pkg::DataW-1:0]    out_value_o,
  output logic                                halted_o,
  output logic [sme_pkg::StatW-1:0]           status_o
);

  localparam int unsigned W   = sme_pkg::DataW;
  localparam int unsigned PW  = sme_pkg::PcW;
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned HAW = (HEAP_ENTRIES > 1) ? $clog2(HEAP_ENTRIES) : 1;
  localparam int unsigned HCW = $clog2(HEAP_ENTRIES + 1);
  localparam int unsigned RAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(CALL_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RD1    = 11'b00000000010,
    S_RD2    = 11'b00000000100,
    S_EXEC   = 11'b00000001000,
    S_MUL    = 11'b00000010000,
    S_DIV    = 11'b00000100000,
    S_HSCAN  = 11'b00001000000,
    S_HWAIT  = 11'b00010000000,
    S_HDONE  = 11'b00100000000,
    S_WB2    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0] stk_mem [STACK_DEPTH];
  logic [W-1:0] hkey_mem [HEAP_ENTRIES];
  logic [W-1:0] hval_mem [HEAP_ENTRIES];
  logic [PW-1:0] ret_mem [CALL_DEPTH];
  logic [HEAP_ENTRIES-1:0] hvalid_q;

  logic [SCW-1:0] cnt_q, cnt_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic [PW-1:0]  pc_q, pc_d;

  logic [sme_pkg::OpW-1:0] op_q;
  logic [W-1:0] arg_q, inv_q;
  logic [W-1:0] top_q, sec_q, val_q;
  logic [W-1:0] stk_rd, hkey_rd, hval_rd;
  logic [PW-1:0] ret_rd;

  logic stk_we, hk_we, hv_we, ret_we, hvalid_set;
  logic [SAW-1:0] stk_wa, stk_ra;
  logic [W-1:0] stk_wd, hk_wd, hv_wd;
  logic [HAW-1:0] h_wa, h_ra;
  logic [RAW-1:0] ret_a;
  logic [PW-1:0] ret_wd;

  logic [HCW-1:0] hidx_q, hidx_d;
  logic [HCW-1:0] hfree_q, hfree_d;
  logic           hfound_q, hfound_d, hfreeok_q, hfreeok_d;
  logic [HAW-1:0] hslot_q, hslot_d;
  logic           hchk_q, hchk_d;
  logic [HAW-1:0] hchki_q, hchki_d;

  logic [W-1:0] prod_q, prod_d;

  logic [PW-1:0]          o_pc_q, o_pc_d;
  logic [sme_pkg::KindW-1:0] o_kind_q, o_kind_d;
  logic [W-1:0]           o_val_q, o_val_d;
  logic                   o_halt_q, o_halt_d;
  logic [sme_pkg::StatW-1:0] o_st_q, o_st_d;
  logic                   o_vld_q, o_vld_d;

  sme_pkg::div_req_t  div_req;
  sme_pkg::div_stat_t div_stat;
  logic [W-1:0]       div_res;

  logic [PW-1:0] np;
  logic [W:0]    argx, cntx;
  logic          arg_ok_pc, arg_lt_n;
  logic          in_acc, out_acc;
  logic [sme_pkg::StatW-1:0] st;
  logic          fin;

  sme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (sec_q),
    .den_i  (top_q),
    .stat_o (div_stat),
    .res_o  (div_res)
  );

  function automatic logic [PW-1:0] pc_after(input logic [PW-1:0] p);
    pc_after = ({1'b0, p} + (PW+1)'(1) >= (PW+1)'(PROG_WORDS)) ? '0 : p + PW'(1);
  endfunction

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = o_vld_q && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  assign argx      = {arg_q[W-1], arg_q};
  assign cntx      = (W+1)'(cnt_q);
  assign arg_ok_pc = !arg_q[W-1] && ({1'b0, arg_q} < (W+1)'(PROG_WORDS));
  assign arg_lt_n  = !arg_q[W-1] && ($signed(argx) < $signed(cntx));

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hk_we) hkey_mem[h_wa] <= hk_wd;
    hkey_rd <= hkey_mem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hv_we) hval_mem[h_wa] <= hv_wd;
    hval_rd <= hval_mem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ret_we) ret_mem[ret_a] <= ret_wd;
    ret_rd <= ret_mem[ret_a];
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rcnt_d   = rcnt_q;
    pc_d     = pc_q;
    hidx_d   = hidx_q;
    hfree_d  = hfree_q;
    hfound_d = hfound_q;
    hfreeok_d = hfreeok_q;
    hslot_d  = hslot_q;
    hchk_d   = 1'b0;
    hchki_d  = hchki_q;
    prod_d   = prod_q;
    o_pc_d   = o_pc_q;
    o_kind_d = o_kind_q;
    o_val_d  = o_val_q;
    o_halt_d = o_halt_q;
    o_st_d   = o_st_q;
    o_vld_d  = o_vld_q && !out_acc;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
    hk_we = 1'b0; hv_we = 1'b0; hvalid_set = 1'b0;
    h_wa = '0; h_ra = '0; hk_wd = '0; hv_wd = '0;
    ret_we = 1'b0; ret_a = '0; ret_wd = '0;
    div_req.start = 1'b0;
    div_req.is_mod = (op_q == sme_pkg::OP_MOD);
    np  = pc_after(pc_q);
    st  = sme_pkg::ST_OK;
    fin = 1'b0;
    o_kind_d = sme_pkg::KIND_NONE;
    o_val_d  = o_val_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_RD1;
        stk_ra = SAW'(cnt_q - SCW'(1));
      end
      S_RD1: begin
        stk_ra = SAW'(cnt_q - SCW'(2));
        state_d = S_RD2;
      end
      S_RD2: begin
        stk_ra = SAW'(cnt_q - SCW'(1) - SCW'(arg_q[SAW-1:0]));
        ret_a  = RAW'(rcnt_q - RCW'(1));
        state_d = S_EXEC;
      end
      S_EXEC: begin
        fin = 1'b1;
        o_val_d = '0;
        case (op_q)
          sme_pkg::OP_PUSH: begin
            if (cnt_q >= SCW'(STACK_DEPTH)) st = sme_pkg::ST_SFULL;
            else begin
              stk_we = 1'b1; stk_wa = SAW'(cnt_q); stk_wd = arg_q;
              cnt_d = cnt_q + SCW'(1);
            end
          end
          sme_pkg::OP_COPY: begin
            if (!arg_lt_n) st = sme_pkg::ST_RANGE;
            else if (cnt_q >= SCW'(STACK_DEPTH)) st = sme_pkg::ST_SFULL;
            else begin
              stk_we = 1'b1; stk_wa = SAW'(cnt_q); stk_wd = stk_rd;
              cnt_d = cnt_q + SCW'(1);
            end
          end
          sme_pkg::OP_SLIDE: begin
            if (cnt_q == '0) st = sme_pkg::ST_UNDER;
            else begin
              cnt_d = arg_lt_n ? cnt_q - SCW'(arg_q[SCW-1:0]) : SCW'(1);
              stk_we = 1'b1; stk_wa = SAW'(cnt_d - SCW'(1)); stk_wd = top_q;
            end
          end
          sme_pkg::OP_DUP: begin
            if (cnt_q == '0) st = sme_pkg::ST_UNDER;
            else if (cnt_q >= SCW'(STACK_DEPTH)) st = sme_pkg::ST_SFULL;
            else begin
              stk_we = 1'b1; stk_wa = SAW'(cnt_q); stk_wd = top_q;
              cnt_d = cnt_q + SCW'(1);
            end
          end
          sme_pkg::OP_SWAP: begin
            if (cnt_q < SCW'(2)) st = sme_pkg::ST_UNDER;
            else begin
              stk_we = 1'b1; stk_wa = SAW'(cnt_q - SCW'(1)); stk_wd = sec_q;
              fin = 1'b0; state_d = S_WB2;
            end
          end
          sme_pkg::OP_DROP: begin
            if (cnt_q == '0) st = sme_pkg::ST_UNDER;
            else cnt_d = cnt_q - SCW'(1);
          end
          sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
            if (cnt_q < SCW'(2)) st = sme_pkg::ST_UNDER;
            else begin
              stk_we = 1'b1; stk_wa = SAW'(cnt_q - SCW'(2));
              stk_wd = (op_q == sme_pkg::OP_ADD) ? sec_q + top_q : sec_q - top_q;
              cnt_d = cnt_q - SCW'(1);
            end
          end
          sme_pkg::OP_MUL: begin
            if (cnt_q < SCW'(2)) st = sme_pkg::ST_UNDER;
            else begin
              prod_d = W'(sec_q * top_q);
              fin = 1'b0; state_d = S_MUL;
            end
          end
          sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
            if (cnt_q < SCW'(2)) st = sme_pkg::ST_UNDER;
            else if (top_q == '0) st = sme_pkg::ST_DIVZERO;
            else begin
              div_req.start = 1'b1;
              fin = 1'b0; state_d = S_DIV;
            end
          end
          sme_pkg::OP_STORE, sme_pkg::OP_LOAD, sme_pkg::OP_INC, sme_pkg::OP_INN: begin
            if (cnt_q < ((op_q == sme_pkg::OP_STORE) ? SCW'(2) : SCW'(1))) begin
              st = sme_pkg::ST_UNDER;
            end else begin
              hidx_d = '0; hfound_d = 1'b0; hfreeok_d = 1'b0;
              fin = 1'b0; state_d = S_HSCAN;
            end
          end
          sme_pkg::OP_OUTC, sme_pkg::OP_OUTN: begin
            if (cnt_q == '0) st = sme_pkg::ST_UNDER;
            else begin
              cnt_d = cnt_q - SCW'(1);
              o_kind_d = (op_q == sme_pkg::OP_OUTC) ? sme_pkg::KIND_CHAR : sme_pkg::KIND_NUM;
              o_val_d  = (op_q == sme_pkg::OP_OUTC) ? {24'd0, top_q[7:0]} : top_q;
            end
          end
          sme_pkg::OP_CALL: begin
            if (!arg_ok_pc) st = sme_pkg::ST_RANGE;
            else if (rcnt_q >= RCW'(CALL_DEPTH)) st = sme_pkg::ST_RFULL;
            else begin
              ret_we = 1'b1; ret_a = RAW'(rcnt_q); ret_wd = pc_q;
              rcnt_d = rcnt_q + RCW'(1);
              np = PW'(arg_q);
            end
          end
          sme_pkg::OP_JUMP: begin
            if (!arg_ok_pc) st = sme_pkg::ST_RANGE;
            else np = PW'(arg_q);
          end
          sme_pkg::OP_BZ, sme_pkg::OP_BN: begin
            if (cnt_q == '0) st = sme_pkg::ST_UNDER;
            else if ((op_q == sme_pkg::OP_BZ) ? (top_q == '0) : top_q[W-1]) begin
              if (!arg_ok_pc) st = sme_pkg::ST_RANGE;
              else begin
                np = PW'(arg_q);
                cnt_d = cnt_q - SCW'(1);
              end
            end else cnt_d = cnt_q - SCW'(1);
          end
          sme_pkg::OP_RET: begin
            if (rcnt_q == '0) st = sme_pkg::ST_NORET;
            else begin
              rcnt_d = rcnt_q - RCW'(1);
              np = pc_after(ret_rd);
            end
          end
          sme_pkg::OP_EXIT: np = pc_q;
          default: st = sme_pkg::ST_NOEXIT;
        endcase
      end
      S_WB2: begin
        stk_we = 1'b1; stk_wa = SAW'(cnt_q - SCW'(2)); stk_wd = top_q;
        fin = 1'b1; o_val_d = '0;
      end
      S_MUL: begin
        stk_we = 1'b1; stk_wa = SAW'(cnt_q - SCW'(2)); stk_wd = prod_q;
        cnt_d = cnt_q - SCW'(1);
        fin = 1'b1; o_val_d = '0;
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_we = 1'b1; stk_wa = SAW'(cnt_q - SCW'(2)); stk_wd = div_res;
          cnt_d = cnt_q - SCW'(1);
          fin = 1'b1; o_val_d = '0;
        end
      end
      S_HSCAN: begin
        if (hchk_q && hvalid_q[hchki_q] && hkey_rd == val_q) begin
          hfound_d = 1'b1; hslot_d = hchki_q;
          state_d = S_HDONE;
        end else if (hidx_q == HCW'(HEAP_ENTRIES)) begin
          state_d = S_HWAIT;
        end else begin
          h_ra = HAW'(hidx_q);
          hchk_d = 1'b1; hchki_d = HAW'(hidx_q);
          if (!hvalid_q[HAW'(hidx_q)] && !hfreeok_q) begin
            hfreeok_d = 1'b1; hfree_d = hidx_q;
          end
          hidx_d = hidx_q + HCW'(1);
        end
        if (state_d == S_HDONE) h_ra = hchki_q;
      end
      S_HWAIT: begin
        h_ra = hslot_q;
        state_d = S_HDONE;
      end
      S_HDONE: begin
        fin = 1'b1; o_val_d = '0;
        if (op_q == sme_pkg::OP_LOAD) begin
          if (!hfound_q) st = sme_pkg::ST_UNSET;
          else begin
            stk_we = 1'b1; stk_wa = SAW'(cnt_q - SCW'(1)); stk_wd = hval_rd;
          end
        end else if (!hfound_q && !hfreeok_q) begin
          st = sme_pkg::ST_HFULL;
        end else begin
          h_wa = hfound_q ? hslot_q : HAW'(hfree_q);
          hk_we = 1'b1; hv_we = 1'b1; hvalid_set = 1'b1;
          hk_wd = val_q;
          if (op_q == sme_pkg::OP_STORE) begin
            hv_wd = top_q;
            cnt_d = cnt_q - SCW'(2);
          end else begin
            hv_wd = (op_q == sme_pkg::OP_INC) ? {24'd0, inv_q[7:0]} : inv_q;
            cnt_d = cnt_q - SCW'(1);
          end
        end
      end
      S_OUT: begin
        if (out_acc) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      state_d = S_OUT;
      o_vld_d = 1'b1;
      if (st != sme_pkg::ST_OK) begin
        stk_we = 1'b0; hk_we = 1'b0; hv_we = 1'b0; hvalid_set = 1'b0; ret_we = 1'b0;
        cnt_d = cnt_q; rcnt_d = rcnt_q;
        o_pc_d = pc_q; o_kind_d = sme_pkg::KIND_NONE; o_val_d = '0;
        o_halt_d = 1'b1;
      end else begin
        o_pc_d = np; pc_d = np;
        o_halt_d = (op_q == sme_pkg::OP_EXIT);
      end
      o_st_d = st;
    end else begin
      o_kind_d = o_kind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rcnt_q   <= '0;
      pc_q     <= '0;
      hvalid_q <= '0;
      o_vld_q  <= 1'b0;
      hchk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rcnt_q  <= rcnt_d;
      pc_q    <= pc_d;
      o_vld_q <= o_vld_d;
      hchk_q  <= hchk_d;
      if (hvalid_set) hvalid_q[h_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      arg_q <= operand_i;
      inv_q <= in_value_i;
    end
    if (state_q == S_RD1) top_q <= stk_rd;
    if (state_q == S_RD2) sec_q <= stk_rd;
    if (state_q == S_EXEC) begin
      val_q <= (op_q == sme_pkg::OP_STORE) ? sec_q : top_q;
    end
    hidx_q    <= hidx_d;
    hfree_q   <= hfree_d;
    hfound_q  <= hfound_d;
    hfreeok_q <= hfreeok_d;
    hslot_q   <= hslot_d;
    hchki_q   <= hchki_d;
    prod_q    <= prod_d;
    o_pc_q    <= o_pc_d;
    o_kind_q  <= o_kind_d;
    o_val_q   <= o_val_d;
    o_halt_q  <= o_halt_d;
    o_st_q    <= o_st_d;
  end

  assign out_valid_o = o_vld_q;
  assign next_pc_o   = o_pc_q;
  assign out_kind_o  = o_kind_q;
  assign out_value_o = o_val_q;
  assign halted_o    = o_halt_q;
  assign status_o    = o_st_q;

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !o_vld_q) else $error("input ready while result pending");
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_st_q != sme_pkg::ST_OK) |-> (o_halt_q && o_kind_q == sme_pkg::KIND_NONE))
    else $error("error result not halted");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SCW'(STACK_DEPTH)) else $error("stack count overrun");
  a_rcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RCW'(CALL_DEPTH)) else $error("return count overrun");
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV) else $error("divider busy outside divide");
`endif

endmodule

// ===== hdl/sme_div.sv =====
`timescale 1ns / 1ps
module sme_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sme_pkg::div_req_t            req_i,
  input  logic [sme_pkg::DataW-1:0]    num_i,
  input  logic [sme_pkg::DataW-1:0]    den_i,
  output sme_pkg::div_stat_t           stat_o,
  output logic [sme_pkg::DataW-1:0]    res_o
);

  localparam int unsigned W  = sme_pkg::DataW;
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic          nneg_q, nneg_d, dneg_q, dneg_d, mod_q, mod_d;
  logic [W:0]    trial;
  logic [W-1:0]  shrem, qs, rs, rf;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nneg_d = nneg_q;
    dneg_d = dneg_q;
    mod_d  = mod_q;
    shrem  = {rem_q[W-2:0], quo_q[W-1]};
    trial  = {1'b0, shrem} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      nneg_d = num_i[W-1];
      dneg_d = den_i[W-1];
      mod_d  = req_i.is_mod;
      quo_d  = num_i[W-1] ? -num_i : num_i;
      den_d  = den_i[W-1] ? -den_i : den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shrem;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    qs = (nneg_q ^ dneg_q) ? -quo_q : quo_q;
    rs = nneg_q ? -rem_q : rem_q;
    rf = dneg_q ? -den_q : den_q;
    if (mod_q) begin
      res_o = ((rem_q != '0) && (nneg_q != dneg_q)) ? rs + rf : rs;
    end else begin
      res_o = ((rem_q != '0) && (nneg_q != dneg_q)) ? qs - W'(1) : qs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    nneg_q <= nneg_d;
    dneg_q <= dneg_d;
    mod_q  <= mod_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== test/stack_machine_executor_top_test.sv =====
`timescale 1ns / 1ps
module stack_machine_executor_top_test;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCycles = 400;

  typedef struct packed {
    logic [sme_pkg::PcW-1:0]   pc;
    logic [sme_pkg::KindW-1:0] kind;
    logic [sme_pkg::DataW-1:0] val;
    logic                      halt;
    logic [sme_pkg::StatW-1:0] st;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [sme_pkg::OpW-1:0] opcode = '0;
  logic [sme_pkg::DataW-1:0] operand = '0;
  logic [sme_pkg::DataW-1:0] in_value = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [sme_pkg::PcW-1:0] next_pc;
  logic [sme_pkg::KindW-1:0] out_kind;
  logic [sme_pkg::DataW-1:0] out_value;
  logic halted;
  logic [sme_pkg::StatW-1:0] status;

  stack_machine_executor_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .operand_i(operand), .in_value_i(in_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .next_pc_o(next_pc), .out_kind_o(out_kind), .out_value_o(out_value),
    .halted_o(halted), .status_o(status)
  );

  logic [sme_pkg::DataW-1:0] op_stack [sme_pkg::StackDepth];
  int unsigned               stack_n = 0;
  logic [sme_pkg::DataW-1:0] heap_key [sme_pkg::HeapEntries];
  logic [sme_pkg::DataW-1:0] heap_val [sme_pkg::HeapEntries];
  bit                        heap_used [sme_pkg::HeapEntries];
  logic [sme_pkg::PcW-1:0]   ret_stack [sme_pkg::CallDepth];
  int unsigned               ret_n = 0;
  logic [sme_pkg::PcW-1:0]   cur_pc = '0;

  result_t     expected_q[$];
  int          errors = 0;
  int unsigned burst_left = 0;
  int unsigned rx_stall_pct = 20;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [sme_pkg::PcW-1:0] pc_next(logic [sme_pkg::PcW-1:0] p);
    return (p == sme_pkg::PcW'(sme_pkg::ProgWords - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic int heap_lookup(logic [sme_pkg::DataW-1:0] k);
    for (int i = 0; i < sme_pkg::HeapEntries; i++) begin
      if (heap_used[i] && heap_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int heap_place(logic [sme_pkg::DataW-1:0] k);
    int slot;
    slot = heap_lookup(k);
    if (slot >= 0) return slot;
    for (int i = 0; i < sme_pkg::HeapEntries; i++) begin
      if (!heap_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic int heap_free();
    int f;
    f = 0;
    for (int i = 0; i < sme_pkg::HeapEntries; i++) begin
      if (!heap_used[i]) f++;
    end
    return f;
  endfunction

  function automatic result_t execute(logic [sme_pkg::OpW-1:0] op,
                                      logic [sme_pkg::DataW-1:0] arg,
                                      logic [sme_pkg::DataW-1:0] inv);
    int unsigned n;
    logic [sme_pkg::DataW-1:0] top, sec;
    longint a, b, q, argl;
    logic [sme_pkg::PcW-1:0] np;
    logic [sme_pkg::StatW-1:0] st;
    logic [sme_pkg::KindW-1:0] kind;
    logic [sme_pkg::DataW-1:0] val;
    logic halt;
    bit taken;
    int slot;
    result_t r;
    n = stack_n;
    top = (n > 0) ? op_stack[n-1] : '0;
    sec = (n > 1) ? op_stack[n-2] : '0;
    a = longint'($signed(top));
    b = longint'($signed(sec));
    argl = longint'($signed(arg));
    np = pc_next(cur_pc);
    st = sme_pkg::ST_OK;
    kind = sme_pkg::KIND_NONE;
    val = '0;
    halt = 1'b0;
    q = 0;
    case (op)
      sme_pkg::OP_PUSH: begin
        if (n >= sme_pkg::StackDepth) st = sme_pkg::ST_SFULL;
        else begin
          op_stack[n] = arg;
          stack_n = n + 1;
        end
      end
      sme_pkg::OP_COPY: begin
        if (argl < 0 || argl >= longint'(n)) st = sme_pkg::ST_RANGE;
        else if (n >= sme_pkg::StackDepth) st = sme_pkg::ST_SFULL;
        else begin
          op_stack[n] = op_stack[n - 1 - int'(argl)];
          stack_n = n + 1;
        end
      end
      sme_pkg::OP_SLIDE: begin
        if (n == 0) st = sme_pkg::ST_UNDER;
        else begin
          stack_n = (argl < 0 || argl >= longint'(n)) ? 1 : n - int'(argl);
          op_stack[stack_n - 1] = top;
        end
      end
      sme_pkg::OP_DUP: begin
        if (n < 1) st = sme_pkg::ST_UNDER;
        else if (n >= sme_pkg::StackDepth) st = sme_pkg::ST_SFULL;
        else begin
          op_stack[n] = top;
          stack_n = n + 1;
        end
      end
      sme_pkg::OP_SWAP: begin
        if (n < 2) st = sme_pkg::ST_UNDER;
        else begin
          op_stack[n-1] = sec;
          op_stack[n-2] = top;
        end
      end
      sme_pkg::OP_DROP: begin
        if (n < 1) st = sme_pkg::ST_UNDER;
        else stack_n = n - 1;
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
      sme_pkg::OP_MOD: begin
        if (n < 2) st = sme_pkg::ST_UNDER;
        else if ((op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD) && a == 0) begin
          st = sme_pkg::ST_DIVZERO;
        end else begin
          case (op)
            sme_pkg::OP_ADD: q = longint'(sec + top);
            sme_pkg::OP_SUB: q = longint'(sec - top);
            sme_pkg::OP_MUL: q = b * a;
            sme_pkg::OP_DIV: begin
              q = b / a;
              if ((b % a) != 0 && ((b < 0) != (a < 0))) q = q - 1;
            end
            default: begin
              q = b % a;
              if (q != 0 && ((q < 0) != (a < 0))) q = q + a;
            end
          endcase
          op_stack[n-2] = q[sme_pkg::DataW-1:0];
          stack_n = n - 1;
        end
      end
      sme_pkg::OP_STORE: begin
        if (n < 2) st = sme_pkg::ST_UNDER;
        else begin
          slot = heap_place(sec);
          if (slot < 0) st = sme_pkg::ST_HFULL;
          else begin
            heap_key[slot] = sec;
            heap_val[slot] = top;
            heap_used[slot] = 1'b1;
            stack_n = n - 2;
          end
        end
      end
      sme_pkg::OP_LOAD: begin
        if (n < 1) st = sme_pkg::ST_UNDER;
        else begin
          slot = heap_lookup(top);
          if (slot < 0) st = sme_pkg::ST_UNSET;
          else op_stack[n-1] = heap_val[slot];
        end
      end
      sme_pkg::OP_OUTC, sme_pkg::OP_OUTN: begin
        if (n < 1) st = sme_pkg::ST_UNDER;
        else begin
          kind = (op == sme_pkg::OP_OUTC) ? sme_pkg::KIND_CHAR : sme_pkg::KIND_NUM;
          val = (op == sme_pkg::OP_OUTC) ? {24'd0, top[7:0]} : top;
          stack_n = n - 1;
        end
      end
      sme_pkg::OP_INC, sme_pkg::OP_INN: begin
        if (n < 1) st = sme_pkg::ST_UNDER;
        else begin
          slot = heap_place(top);
          if (slot < 0) st = sme_pkg::ST_HFULL;
          else begin
            heap_key[slot] = top;
            heap_val[slot] = (op == sme_pkg::OP_INC) ? {24'd0, inv[7:0]} : inv;
            heap_used[slot] = 1'b1;
            stack_n = n - 1;
          end
        end
      end
      sme_pkg::OP_CALL: begin
        if (argl < 0 || argl >= sme_pkg::ProgWords) st = sme_pkg::ST_RANGE;
        else if (ret_n >= sme_pkg::CallDepth) st = sme_pkg::ST_RFULL;
        else begin
          ret_stack[ret_n] = cur_pc;
          ret_n++;
          np = arg[sme_pkg::PcW-1:0];
        end
      end
      sme_pkg::OP_JUMP: begin
        if (argl < 0 || argl >= sme_pkg::ProgWords) st = sme_pkg::ST_RANGE;
        else np = arg[sme_pkg::PcW-1:0];
      end
      sme_pkg::OP_BZ, sme_pkg::OP_BN: begin
        if (n < 1) st = sme_pkg::ST_UNDER;
        else begin
          taken = (op == sme_pkg::OP_BZ) ? (a == 0) : (a < 0);
          if (taken && (argl < 0 || argl >= sme_pkg::ProgWords)) st = sme_pkg::ST_RANGE;
          else begin
            if (taken) np = arg[sme_pkg::PcW-1:0];
            stack_n = n - 1;
          end
        end
      end
      sme_pkg::OP_RET: begin
        if (ret_n == 0) st = sme_pkg::ST_NORET;
        else begin
          ret_n--;
          np = pc_next(ret_stack[ret_n]);
        end
      end
      sme_pkg::OP_EXIT: begin
        halt = 1'b1;
        np = cur_pc;
      end
      default: st = sme_pkg::ST_NOEXIT;
    endcase
    if (st != sme_pkg::ST_OK) begin
      halt = 1'b1;
      np = cur_pc;
      kind = sme_pkg::KIND_NONE;
      val = '0;
    end else begin
      cur_pc = np;
    end
    r.pc = np;
    r.kind = kind;
    r.val = val;
    r.halt = halt;
    r.st = st;
    return r;
  endfunction

  task automatic report(input string field, input logic [sme_pkg::DataW-1:0] got,
                        input logic [sme_pkg::DataW-1:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic send_instr(input logic [sme_pkg::OpW-1:0] op,
                            input logic [sme_pkg::DataW-1:0] arg,
                            input logic [sme_pkg::DataW-1:0] inv = '0);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    opcode <= op;
    operand <= arg;
    in_value <= inv;
    do @(posedge clk); while (!in_ready);
    expected_q.insert(expected_q.size(), execute(op, arg, inv));
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", '0, '0);
      end else begin
        want = expected_q.pop_front();
        if (next_pc !== want.pc) begin
          report("next_pc", sme_pkg::DataW'(next_pc), sme_pkg::DataW'(want.pc));
        end
        if (out_kind !== want.kind) begin
          report("out_kind", sme_pkg::DataW'(out_kind), sme_pkg::DataW'(want.kind));
        end
        if (out_value !== want.val) report("out_value", out_value, want.val);
        if (halted !== want.halt) begin
          report("halted", sme_pkg::DataW'(halted), sme_pkg::DataW'(want.halt));
        end
        if (status !== want.st) begin
          report("status", sme_pkg::DataW'(status), sme_pkg::DataW'(want.st));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_empty_errors();
    send_instr(sme_pkg::OP_DROP, 0);
    send_instr(sme_pkg::OP_DUP, 0);
    send_instr(sme_pkg::OP_SLIDE, 1);
    send_instr(sme_pkg::OP_OUTC, 0);
    send_instr(sme_pkg::OP_LOAD, 0);
    send_instr(sme_pkg::OP_INN, 0, 32'h1234);
    send_instr(sme_pkg::OP_BZ, 3);
    send_instr(sme_pkg::OP_RET, 0);
    send_instr(sme_pkg::OP_END, 0);
    send_instr(5'd24, 0);
    send_instr(5'd31, 32'hFFFF_FFFF);
    send_instr(sme_pkg::OP_JUMP, 32'hFFFF_FFFF);
    send_instr(sme_pkg::OP_JUMP, sme_pkg::ProgWords);
    send_instr(sme_pkg::OP_CALL, 32'h7FFF_FFFF);
    send_instr(sme_pkg::OP_COPY, 0);
    send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
    send_instr(sme_pkg::OP_SWAP, 0);
    send_instr(sme_pkg::OP_ADD, 0);
    send_instr(sme_pkg::OP_STORE, 0);
    send_instr(sme_pkg::OP_EXIT, 0);
    send_instr(sme_pkg::OP_DROP, 0);
  endtask

  task automatic test_arith();
    send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
    send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_instr(sme_pkg::OP_DIV, 0);
    send_instr(sme_pkg::OP_OUTN, 0);
    send_instr(sme_pkg::OP_PUSH, 7);
    send_instr(sme_pkg::OP_PUSH, -2);
    send_instr(sme_pkg::OP_DIV, 0);
    send_instr(sme_pkg::OP_PUSH, 7);
    send_instr(sme_pkg::OP_PUSH, -2);
    send_instr(sme_pkg::OP_MOD, 0);
    send_instr(sme_pkg::OP_PUSH, -7);
    send_instr(sme_pkg::OP_PUSH, 2);
    send_instr(sme_pkg::OP_MOD, 0);
    send_instr(sme_pkg::OP_PUSH, 0);
    send_instr(sme_pkg::OP_DIV, 0);
    send_instr(sme_pkg::OP_MOD, 0);
    send_instr(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_instr(sme_pkg::OP_MUL, 0);
    send_instr(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_instr(sme_pkg::OP_ADD, 0);
    send_instr(sme_pkg::OP_SUB, 0);
    send_instr(sme_pkg::OP_OUTN, 0);
    send_instr(sme_pkg::OP_SLIDE, 32'h8000_0000);
    send_instr(sme_pkg::OP_OUTN, 0);
  endtask

  task automatic test_heap_io();
    send_instr(sme_pkg::OP_PUSH, 5);
    send_instr(sme_pkg::OP_INN, 0, 32'h8000_0001);
    send_instr(sme_pkg::OP_PUSH, 5);
    send_instr(sme_pkg::OP_LOAD, 0);
    send_instr(sme_pkg::OP_OUTN, 0);
    send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_instr(sme_pkg::OP_INC, 0, 32'hFFFF_FE9A);
    send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_instr(sme_pkg::OP_LOAD, 0);
    send_instr(sme_pkg::OP_OUTC, 0);
    send_instr(sme_pkg::OP_PUSH, 5);
    send_instr(sme_pkg::OP_PUSH, 32'h0000_01FF);
    send_instr(sme_pkg::OP_STORE, 0);
    send_instr(sme_pkg::OP_PUSH, 5);
    send_instr(sme_pkg::OP_LOAD, 0);
    send_instr(sme_pkg::OP_OUTC, 0);
    send_instr(sme_pkg::OP_PUSH, 99);
    send_instr(sme_pkg::OP_LOAD, 0);
    send_instr(sme_pkg::OP_DROP, 0);
  endtask

  task automatic test_flow();
    send_instr(sme_pkg::OP_CALL, sme_pkg::ProgWords - 1);
    send_instr(sme_pkg::OP_RET, 0);
    send_instr(sme_pkg::OP_JUMP, sme_pkg::ProgWords - 1);
    send_instr(sme_pkg::OP_JUMP, 0);
    send_instr(sme_pkg::OP_PUSH, 0);
    send_instr(sme_pkg::OP_BZ, 17);
    send_instr(sme_pkg::OP_PUSH, -1);
    send_instr(sme_pkg::OP_BN, sme_pkg::ProgWords - 1);
    send_instr(sme_pkg::OP_PUSH, 1);
    send_instr(sme_pkg::OP_BZ, -5);
    send_instr(sme_pkg::OP_PUSH, -1);
    send_instr(sme_pkg::OP_BN, 2000);
    send_instr(sme_pkg::OP_BN, 32'h8000_0000);
    send_instr(sme_pkg::OP_PUSH, 3);
    send_instr(sme_pkg::OP_COPY, 0);
    send_instr(sme_pkg::OP_COPY, 1);
    send_instr(sme_pkg::OP_COPY, -1);
    send_instr(sme_pkg::OP_COPY, 100);
    send_instr(sme_pkg::OP_SLIDE, 1);
    send_instr(sme_pkg::OP_SLIDE, 32'h7FFF_FFFF);
    send_instr(sme_pkg::OP_EXIT, 0);
    send_instr(sme_pkg::OP_DROP, 0);
  endtask

  task automatic test_stack_full();
    while (stack_n < sme_pkg::StackDepth) send_instr(sme_pkg::OP_PUSH, $urandom);
    send_instr(sme_pkg::OP_PUSH, 1);
    send_instr(sme_pkg::OP_DUP, 0);
    send_instr(sme_pkg::OP_COPY, sme_pkg::StackDepth - 1);
    send_instr(sme_pkg::OP_COPY, sme_pkg::StackDepth);
    send_instr(sme_pkg::OP_SWAP, 0);
    send_instr(sme_pkg::OP_SLIDE, sme_pkg::StackDepth - 2);
    send_instr(sme_pkg::OP_SLIDE, -1);
    send_instr(sme_pkg::OP_DROP, 0);
  endtask

  task automatic test_return_full();
    while (ret_n < sme_pkg::CallDepth) begin
      send_instr(sme_pkg::OP_CALL, $urandom_range(0, sme_pkg::ProgWords - 1));
    end
    send_instr(sme_pkg::OP_CALL, 0);
    while (ret_n > 0) send_instr(sme_pkg::OP_RET, 0);
    send_instr(sme_pkg::OP_RET, 0);
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned pick;
    logic [sme_pkg::DataW-1:0] arg;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      arg = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
      if (k % 200 == 0) begin
        rx_stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 60);
      end
      if (pick < 5) begin
        send_instr(5'($urandom_range(0, 31)), $urandom, $urandom);
      end else if (stack_n < 2 || (pick < 30 && stack_n < 40)) begin
        send_instr(sme_pkg::OP_PUSH, arg);
      end else if (pick < 50) begin
        case ($urandom_range(0, 4))
          0: send_instr(sme_pkg::OP_ADD, 0);
          1: send_instr(sme_pkg::OP_SUB, 0);
          2: send_instr(sme_pkg::OP_MUL, 0);
          3: send_instr(sme_pkg::OP_DIV, 0);
          default: send_instr(sme_pkg::OP_MOD, 0);
        endcase
      end else if (pick < 62) begin
        case ($urandom_range(0, 5))
          0: send_instr(sme_pkg::OP_COPY, $urandom_range(0, stack_n));
          1: send_instr(sme_pkg::OP_SLIDE,
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
          2: send_instr(sme_pkg::OP_DUP, 0);
          3: send_instr(sme_pkg::OP_SWAP, 0);
          4: send_instr(sme_pkg::OP_DROP, 0);
          default: send_instr(sme_pkg::OP_COPY, $urandom);
        endcase
      end else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0: send_instr(sme_pkg::OP_STORE, 0);
          1: send_instr(sme_pkg::OP_LOAD, 0);
          2: send_instr(sme_pkg::OP_INC, 0, $urandom);
          default: send_instr(sme_pkg::OP_INN, 0, $urandom);
        endcase
      end else if (pick < 86) begin
        send_instr($urandom_range(0, 1) ? sme_pkg::OP_OUTC : sme_pkg::OP_OUTN, 0);
      end else begin
        arg = ($urandom_range(0, 9) == 0) ? $urandom
                                          : $urandom_range(0, sme_pkg::ProgWords - 1);
        case ($urandom_range(0, 6))
          0: send_instr(sme_pkg::OP_CALL, arg);
          1: send_instr(sme_pkg::OP_RET, 0);
          2: send_instr(sme_pkg::OP_JUMP, arg);
          3: send_instr(sme_pkg::OP_BZ, arg);
          4: send_instr(sme_pkg::OP_BN, arg);
          5: send_instr(sme_pkg::OP_EXIT, 0);
          default: send_instr(sme_pkg::OP_END, $urandom);
        endcase
      end
    end
  endtask

  task automatic test_heap_full();
    logic [sme_pkg::DataW-1:0] key;
    logic [sme_pkg::DataW-1:0] kept;
    kept = 32'h7000_0000;
    while (heap_free() > 0) begin
      key = $urandom;
      if (heap_lookup(key) < 0) begin
        kept = key;
        send_instr(sme_pkg::OP_PUSH, key);
        send_instr(sme_pkg::OP_INN, 0, $urandom);
      end
    end
    send_instr(sme_pkg::OP_PUSH, ~kept);
    send_instr(sme_pkg::OP_INN, 0, 1);
    send_instr(sme_pkg::OP_PUSH, 0);
    send_instr(sme_pkg::OP_STORE, 0);
    send_instr(sme_pkg::OP_DROP, 0);
    send_instr(sme_pkg::OP_DROP, 0);
    send_instr(sme_pkg::OP_PUSH, kept);
    send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
    send_instr(sme_pkg::OP_STORE, 0);
    send_instr(sme_pkg::OP_PUSH, kept);
    send_instr(sme_pkg::OP_LOAD, 0);
    send_instr(sme_pkg::OP_OUTN, 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_errors();
    test_arith();
    drain();
    test_heap_io();
    test_flow();
    rx_stall_pct = 0;
    test_stack_full();
    rx_stall_pct = 30;
    test_return_full();
    drain();
    test_random(950);
    drain();
    rx_stall_pct = 15;
    test_heap_full();
    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== stack_machine_executor_top.f =====
hdl/sme_pkg.sv
hdl/sme_div.sv
hdl/stack_machine_executor_top.sv
test/stack_machine_executor_top_test.sv
